@@ hdl/insrt_pkg.sv @@
`default_nettype none

package insrt_pkg;

    // Capacity of the sort store
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Sequencer state codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_EMRD = 3'd3;
    localparam logic [2:0] S_EMLD = 3'd4;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
        logic               overflow;
    } t_out_item;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_emit;

endpackage

`default_nettype wire

@@ hdl/insrt_cmp.sv @@
`default_nettype none

// Shared signed magnitude compare: a > b
module insrt_cmp (
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic                    o_gt
);
    import insrt_pkg::*;

    assign o_gt = (i_a > i_b);

endmodule

`default_nettype wire

@@ hdl/insrt_seq.sv @@
`default_nettype none

// Insertion sequencer with the sort store
module insrt_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire insrt_pkg::t_in_item i_in,
    input  wire logic               i_out_free,
    input  wire logic               i_gt,
    output logic signed [31:0]      o_cmp_a,
    output logic signed [31:0]      o_cmp_b,
    output logic                    o_ready,
    output insrt_pkg::t_emit        o_emit
);
    import insrt_pkg::*;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic               r_drop, n_drop;
    logic signed [31:0] r_val, n_val;
    logic               r_last, n_last;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0]  r_k, n_k;
    logic signed [31:0] r_rd_data;

    logic signed [31:0] mem [MAX_ITEMS];

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;
    logic               is_final;

    assign o_cmp_a = r_rd_data;
    assign o_cmp_b = r_val;
    assign o_ready = (r_state == S_IDLE);
    assign is_final = (({1'b0, r_k} + CNT_W'(1)) == r_fill);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_drop  = r_drop;
        n_val   = r_val;
        n_last  = r_last;
        n_pos   = r_pos;
        n_k     = r_k;
        rd_en   = 1'b0;
        rd_addr = r_pos - ADDR_W'(1);
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_val;
        o_emit  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_val  = i_in.value;
                    n_last = i_in.last;
                    n_k    = '0;
                    if (r_fill == CNT_W'(MAX_ITEMS)) begin
                        n_drop = 1'b1;
                        if (i_in.last) begin
                            n_state = S_EMRD;
                        end
                    end else if (r_fill == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = i_in.value;
                        n_fill  = CNT_W'(1);
                        if (i_in.last) begin
                            n_state = S_EMRD;
                        end
                    end else begin
                        n_pos   = r_fill[ADDR_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = r_fill[ADDR_W-1:0] - ADDR_W'(1);
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (i_gt) begin
                    // shift the larger entry up one slot
                    wr_data = r_rd_data;
                    n_pos   = r_pos - ADDR_W'(1);
                    if (r_pos == ADDR_W'(1)) begin
                        n_state = S_INS;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_pos - ADDR_W'(2);
                    end
                end else begin
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = r_last ? S_EMRD : S_IDLE;
                end
            end
            S_INS: begin
                wr_en   = 1'b1;
                n_fill  = r_fill + CNT_W'(1);
                n_state = r_last ? S_EMRD : S_IDLE;
            end
            S_EMRD: begin
                rd_en   = 1'b1;
                rd_addr = r_k;
                n_state = S_EMLD;
            end
            S_EMLD: begin
                if (i_out_free) begin
                    o_emit.load              = 1'b1;
                    o_emit.item.sorted_value = r_rd_data;
                    o_emit.item.final_res    = is_final;
                    o_emit.item.overflow     = r_drop;
                    if (is_final) begin
                        n_fill  = '0;
                        n_drop  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + ADDR_W'(1);
                        n_state = S_EMRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_last <= n_last;
        r_pos  <= n_pos;
        r_k    <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_ITEMS))
        else $error("fill count above capacity");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> r_state == S_IDLE)
        else $error("transaction accepted while busy");

    a_pos_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> ({1'b0, r_pos} <= r_fill) && r_pos != '0)
        else $error("insert position out of range");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.load && o_emit.item.final_res |=> r_fill == '0 && !r_drop
            && r_state == S_IDLE)
        else $error("run not cleared after final result");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMRD |-> r_fill != '0)
        else $error("emitting an empty run");

endmodule

`default_nettype wire

@@ hdl/insertion_sorter.sv @@
// Insertion: a value shifts past each larger stored entry in turn, then
//   fills the freed slot; an empty store takes it, a full store drops it.
// Emit: each result is a store read, then an output load, set by the
//   single registered read port of the store; a sink stall holds the load.
// Reset (i_rst_n low, synchronous) empties the run and clears output valid.
`default_nettype none

module insertion_sorter (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire insrt_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output insrt_pkg::t_out_item      o_out_data
);
    import insrt_pkg::*;

    logic               accept;
    logic               seq_ready;
    logic               out_free;
    logic               gt;
    logic signed [31:0] cmp_a;
    logic signed [31:0] cmp_b;
    t_emit              emit;

    logic               r_out_valid;
    t_out_item          r_out_data;

    // Input side: one transaction at a time, taken only while the
    // sequencer waits for work. During an emit a stalled sink holds
    // the sequencer, so pending results then also stall new input.
    assign o_in_stall = !seq_ready;
    assign accept     = i_in_valid && seq_ready;

    // Output register may be reloaded when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // Single compare unit shared by every insertion step
    insrt_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (gt)
    );

    // Sequencer: walks the store from the top down for each insert,
    // then reads the run out in ascending order on the last item
    insrt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in_data),
        .i_out_free (out_free),
        .i_gt       (gt),
        .o_cmp_a    (cmp_a),
        .o_cmp_b    (cmp_b),
        .o_ready    (seq_ready),
        .o_emit     (emit)
    );

    // Output register: valid is control, payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_data <= emit.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ verif/insertion_sorter_tb.sv @@
`default_nettype none

module insertion_sorter_tb;
    import insrt_pkg::*;

    typedef logic signed [31:0] word_t;
    typedef word_t word_q_t[$];

    // Receiver stall behavior, switched in phases of random length
    typedef enum int {
        RX_FLOW,     // never stalls
        RX_CHOPPY,   // stalls about half the time
        RX_CHOKED    // stalls most of the time
    } rx_mode_t;

    localparam word_t WORD_MAX = 32'sh7fff_ffff;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    localparam int TARGET_ITEMS = 370;
    // Long receiver hold-off: long enough to back up a full emit and the input
    localparam int HOLD_CYCLES  = 600;
    // Quiet time at the end to catch stray results
    localparam int DRAIN_CYCLES = 200;
    // Watchdog limit, far above the worst run (full inserts, stalled emits)
    localparam int CYCLE_LIMIT  = 400000;

    // ------------------------------------------------------------------
    // Scoreboard: keeps a sorted copy of the run in progress and the queue
    // of results the block owes us.
    // ------------------------------------------------------------------
    class sort_scoreboard;
        word_t       run_q[$];       // current run, kept in ascending order
        bit          dropped;        // a value of this run did not fit
        t_out_item   owed_q[$];      // results expected, oldest first
        int unsigned errors;

        function new();
            dropped = 1'b0;
            errors  = 0;
        endfunction

        // Insert one accepted transaction; on last, queue the whole run.
        function void note_input(t_in_item tr);
            word_t     v;
            int        pos;
            t_out_item r;
            v = $signed(tr.value);
            if (run_q.size() >= MAX_ITEMS) begin
                dropped = 1'b1;
            end else begin
                // stable: new value only moves ahead of strictly greater ones
                pos = run_q.size();
                while (pos > 0 && run_q[pos-1] > v)
                    pos--;
                run_q.insert(pos, v);
            end
            if (tr.last) begin
                foreach (run_q[k]) begin
                    r.sorted_value = run_q[k];
                    r.final_res    = (k == run_q.size() - 1);
                    r.overflow     = dropped;
                    owed_q.push_back(r);
                end
                run_q.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d final_res %0b overflow %0b",
                       $signed(got.sorted_value), got.final_res, got.overflow);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                $error("sorted_value: expected %0d, actual %0d",
                       $signed(want.sorted_value), $signed(got.sorted_value));
                errors++;
            end
            if (got.final_res !== want.final_res) begin
                $error("final_res: expected %0b, actual %0b", want.final_res, got.final_res);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    insertion_sorter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    sort_scoreboard sb = new();

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    bit          hold_req   = 1'b0;   // asks the receiver for its long hold-off

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sender. Inputs move on the falling edge; a transaction is taken at a
    // rising edge with valid high and stall low. Traffic comes in bursts
    // with random gaps, sometimes none, so the gaps land on every phase of
    // the insert and emit sequencing.
    // ------------------------------------------------------------------
    task automatic send_item(input t_in_item tr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                in_data  <= t_in_item'({$urandom, 1'($urandom)});
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= tr;
        // payload holds steady until the block takes it
        forever begin
            @(posedge i_clk);
            if (!in_stall)
                break;
        end
        sb.note_input(tr);
        burst_left--;
        items_sent++;
    endtask

    // One run: every value in order, last flag on the final one.
    task automatic send_run(input word_q_t vals);
        t_in_item tr;
        foreach (vals[k]) begin
            tr.value = vals[k];
            tr.last  = (k == vals.size() - 1);
            send_item(tr);
        end
    endtask

    // Random run of len values: mostly full-range, some clustered near zero
    // so duplicates show up, a few pinned to the extremes.
    task automatic send_random_run(input int len);
        word_q_t vals;
        int      pick;
        repeat (len) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                vals.push_back(($urandom_range(0, 1) == 1) ? WORD_MAX : WORD_MIN);
            else if (pick <= 3)
                vals.push_back(word_t'($urandom_range(0, 8)) - 4);
            else
                vals.push_back(word_t'($urandom));
        end
        send_run(vals);
    endtask

    // ------------------------------------------------------------------
    // Receiver. Stall changes on the falling edge, following phases of its
    // own. When the stimulus raises hold_req the receiver holds off for a
    // long, counted stretch so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        mode      = RX_FLOW;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    RX_FLOW:   out_stall <= 1'b0;
                    RX_CHOPPY: out_stall <= ($urandom_range(0, 1) == 1);
                    default:   out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // Result check at the rising edge, on the values before the edge updates
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Watchdog
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int r;
        int len;

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed runs
        send_run({word_t'(0)});                                  // run of one
        send_run({WORD_MAX, WORD_MIN, word_t'(-1), word_t'(0), word_t'(1)});
        send_run({word_t'(5), word_t'(-3), word_t'(5), word_t'(-3), word_t'(5)});
        send_run({word_t'(3), word_t'(2), word_t'(1), word_t'(0), word_t'(-1)});  // worst shifts
        send_run({word_t'(-2), word_t'(-1), word_t'(0), word_t'(1)});  // no shifts
        send_run({WORD_MIN});

        // Store exactly full, then a run that overflows with last dropped
        send_random_run(MAX_ITEMS);
        send_random_run(MAX_ITEMS + 3);

        // Random runs, mostly short; now and then full or overflowing
        while (items_sent < TARGET_ITEMS) begin
            if (!hold_req && items_sent >= 200)
                hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 8);
            else if (r < 92)
                len = $urandom_range(9, 40);
            else if (r < 97)
                len = $urandom_range(MAX_ITEMS - 1, MAX_ITEMS);
            else
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            send_random_run(len);
        end

        @(negedge i_clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
